// ----- hw/rtl/ddo_pkg.sv -----
`default_nettype none
package ddo_pkg;

	// stream widths
	localparam int IN_W = 88;
	localparam int OUT_W = 160;
	localparam int IDX_W = 8;

	// rotation steps of the CORDIC, 12 to 32
	localparam int CORDIC_STEPS = 24;
	localparam int CORD_IW = 5;
	localparam int CORD_W = 34;

	localparam logic [31:0] CORDIC_GAIN = 32'd652032875;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [31:0] US_PER_S = 32'd1000000;
	localparam logic [31:0] MPT_RESET = 32'd2623666;
	localparam logic [31:0] TPM_RESET = 32'd7739690;

	typedef enum logic [IDX_W-1:0] {
		REG_MPT = 8'd0,
		REG_TPM = 8'd1
	} reg_idx_t;

	// atan(2^-k) as binary angle
	function automatic logic [31:0] atan_f(input logic [CORD_IW-1:0] k);
		logic [31:0] v;
		case (k)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// clamp to signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [52:0] v);
		logic [31:0] r;
		if (v > 53'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -53'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ddo_mul.sv -----
`default_nettype none
module ddo_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);
	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_div.sv -----
`default_nettype none
module ddo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [23:0] rem
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] div_q;
	logic [24:0] trial;
	logic        fit;

	// restoring, one quotient bit per cycle
	assign trial = {rem_q, quo_q[63]};
	assign fit = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				quo_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[62:0], fit};
				rem_q <= fit ? 24'(trial - {1'b0, div_q}) : trial[23:0];
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_cordic.sv -----
`default_nettype none
module ddo_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [31:0]                       angle,
	output logic                              done,
	output logic signed [ddo_pkg::CORD_W-1:0] cos_val,
	output logic signed [ddo_pkg::CORD_W-1:0] sin_val
);
	import ddo_pkg::*;

	logic                     flip;
	logic [31:0]              afold;
	logic                     busy_q;
	logic                     done_q;
	logic                     flip_q;
	logic [CORD_IW-1:0]       i_q;
	logic signed [CORD_W-1:0] x_q;
	logic signed [CORD_W-1:0] y_q;
	logic signed [CORD_W-1:0] z_q;
	logic signed [CORD_W-1:0] sx;
	logic signed [CORD_W-1:0] sy;
	logic signed [CORD_W-1:0] at;

	// fold into +-quarter turn
	assign flip = angle[31] ^ angle[30];
	assign afold = flip ? {~angle[31], angle[30:0]} : angle;

	assign sx = y_q >>> i_q;
	assign sy = x_q >>> i_q;
	assign at = $signed({{(CORD_W-32){1'b0}}, atan_f(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			flip_q <= 1'b0;
			i_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				flip_q <= flip;
				x_q <= $signed({{(CORD_W-32){1'b0}}, CORDIC_GAIN});
				y_q <= '0;
				z_q <= $signed({{(CORD_W-32){afold[31]}}, afold});
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - sx;
					y_q <= y_q + sy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + sx;
					y_q <= y_q - sy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
				if (i_q == CORD_IW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

// ----- hw/rtl/diff_drive_odometry_unit.sv -----
`default_nettype none
// Channel | Signals                      | Carries
// --------+------------------------------+------------------------------------------
// s       | s_tvalid s_tready s_tdata    | one encoder sample per transaction
// m       | m_tvalid m_tready m_tdata    | one pose/velocity result per transaction
// cfg     | cfg_valid cfg_ready          | register write, cfg_index selects register
//
// One 32x32 multiplier runs 14 products (the two rate products run once per velocity),
// the CORDIC runs while the sequencer waits for it, and four 64-step divisions (two per
// velocity) take the rest.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next sample is taken while it waits for m_tready.
// Reset clears pose, heading, last counts and loads the default scale registers.
// cfg_ready is always high.
module diff_drive_odometry_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ddo_pkg::IN_W-1:0]     s_tdata,  // left_count, right_count, elapsed_us
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ddo_pkg::OUT_W-1:0]    m_tdata,  // pos_x, pos_y, heading, lin_vel, ang_vel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ddo_pkg::IDX_W-1:0]    cfg_index,
	input  logic [31:0]                  cfg_data
);
	import ddo_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_CORD = 7'b0000100,
		S_DIV1 = 7'b0001000,
		S_RMUL = 7'b0010000,
		S_DIV2 = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	// multiplier schedule
	localparam logic [3:0] ST_TL   = 4'd0;   // |sum| * mpt
	localparam logic [3:0] ST_M    = 4'd1;   // |diff| * mpt
	localparam logic [3:0] ST_LO   = 4'd2;   // m low * tpm
	localparam logic [3:0] ST_HT   = 4'd3;   // m high * tpm
	localparam logic [3:0] ST_P5   = 4'd4;   // turns low * 2pi
	localparam logic [3:0] ST_RADM = 4'd5;   // turns high * 2pi
	localparam logic [3:0] ST_CL   = 4'd6;   // step * cos, low
	localparam logic [3:0] ST_XH   = 4'd7;   // step * cos, high -> x
	localparam logic [3:0] ST_SL   = 4'd8;   // step * sin, low
	localparam logic [3:0] ST_YH   = 4'd9;   // step * sin, high -> y
	localparam logic [3:0] ST_AM   = 4'd10;  // quotient * 1e6
	localparam logic [3:0] ST_RM   = 4'd11;  // remainder * 1e6

	state_t        state_q;
	logic [3:0]    step_q;
	logic          ph_q;
	logic          pass_q;
	logic          m_tvalid_q;
	logic [159:0]  out_q;

	logic [31:0]   mpt_q, tpm_q;
	logic [31:0]   last_left_q, last_right_q;
	logic [31:0]   x_q, y_q, ang_q;

	logic [32:0]   smag_q;
	logic          sneg_q;
	logic [31:0]   dmag_q;
	logic          dneg_q;
	logic [23:0]   us_q;
	logic          move_q;
	logic [63:0]   tmag_q, m_q, lo_q, ht_q, p5_q, radm_q, plo_q;
	logic [27:0]   a_q;
	logic          abig_q;
	logic [23:0]   r_q;
	logic [47:0]   am_q;
	logic [31:0]   lin_q, angv_q;

	// input decode
	logic [31:0]   dl, dr;
	logic [32:0]   sum33, dd33, dmag33;

	assign dl = s_tdata[31:0] - last_left_q;
	assign dr = s_tdata[63:32] - last_right_q;
	assign sum33 = {dl[31], dl} + {dr[31], dr};
	assign dd33 = {dr[31], dr} - {dl[31], dl};
	assign dmag33 = dd33[32] ? (~dd33 + 33'd1) : dd33;

	// travel sign and |travel >> 16|
	logic          tneg;
	logic [64:0]   u65;
	logic [47:0]   ua;

	assign tneg = sneg_q && (tmag_q != 64'd0);
	assign u65 = {1'b0, tmag_q} + 65'h0_0000_0000_0000_FFFF;
	assign ua = tneg ? u65[63:16] : tmag_q[63:16];

	// heading step: bits 24..55 of the signed product
	logic [55:0]   full56, prod56;
	logic [31:0]   dth;

	assign full56 = lo_q[55:0] + {ht_q[23:0], 32'd0};
	assign prod56 = dneg_q ? (~full56 + 56'd1) : full56;
	assign dth = prod56[55:24];

	// |turns| in Q.32, capped at 2^20 turns
	logic [52:0]   tsum, tm;

	assign tsum = {1'b0, ht_q[43:0], 8'd0} + {13'd0, lo_q[63:24]};
	always_comb begin
		if (|ht_q[63:44])
			tm = 53'h10_0000_0000_0000;
		else if (tsum > 53'h10_0000_0000_0000)
			tm = 53'h10_0000_0000_0000;
		else
			tm = tsum;
	end

	// shared units
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   prod_q;
	logic          cord_start, cord_done;
	logic signed [CORD_W-1:0] cos_v, sin_v;
	logic [31:0]   ucos, usin;
	logic          div_start, div_done;
	logic [63:0]   div_dividend, div_quot;
	logic [23:0]   div_rem;

	assign ucos = cos_v[CORD_W-1] ? 32'(-cos_v) : cos_v[31:0];
	assign usin = sin_v[CORD_W-1] ? 32'(-sin_v) : sin_v[31:0];

	always_comb begin
		case (step_q)
			ST_TL:   begin mul_a = smag_q[31:0]; mul_b = mpt_q; end
			ST_M:    begin mul_a = dmag_q; mul_b = mpt_q; end
			ST_LO:   begin mul_a = m_q[31:0]; mul_b = tpm_q; end
			ST_HT:   begin mul_a = m_q[63:32]; mul_b = tpm_q; end
			ST_P5:   begin mul_a = tm[31:0]; mul_b = TWO_PI_Q29; end
			ST_RADM: begin mul_a = {11'd0, tm[52:32]}; mul_b = TWO_PI_Q29; end
			ST_CL:   begin mul_a = ua[31:0]; mul_b = ucos; end
			ST_XH:   begin mul_a = {16'd0, ua[47:32]}; mul_b = ucos; end
			ST_SL:   begin mul_a = ua[31:0]; mul_b = usin; end
			ST_YH:   begin mul_a = {16'd0, ua[47:32]}; mul_b = usin; end
			ST_AM:   begin mul_a = {4'd0, a_q}; mul_b = US_PER_S; end
			ST_RM:   begin mul_a = {8'd0, r_q}; mul_b = US_PER_S; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	ddo_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod_q)
	);

	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.angle   (ang_q - dth),
		.done    (cord_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	ddo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (us_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// position step, magnitude (high part from the multiplier, low part held)
	logic [50:0]   pstep;
	logic          xneg, yneg;
	logic [52:0]   xs, ys;

	assign pstep = {1'b0, prod_q[47:0], 2'b00} + {17'd0, plo_q[63:30]};
	assign xneg = tneg ^ cos_v[CORD_W-1];
	assign yneg = tneg ^ sin_v[CORD_W-1];
	assign xs = {{21{x_q[31]}}, x_q} + (xneg ? (~{2'b00, pstep} + 53'd1) : {2'b00, pstep});
	assign ys = {{21{y_q[31]}}, y_q} + (yneg ? (~{2'b00, pstep} + 53'd1) : {2'b00, pstep});

	// velocity finish: (a*1e6 + r*1e6/us) >> 16, signed and clamped
	logic [48:0]   raw49;
	logic [32:0]   raw33, vm;
	logic          vneg;
	logic [31:0]   vel;

	assign raw49 = {1'b0, am_q} + {29'd0, div_quot[19:0]};
	assign raw33 = abig_q ? 33'h1_0000_0000 : raw49[48:16];
	assign vneg = pass_q ? dneg_q : tneg;
	assign vm = (raw33 > 33'h0_8000_0000) ? 33'h0_8000_0000 : raw33;

	always_comb begin
		if (us_q == 24'd0)
			vel = '0;
		else if (vneg)
			vel = 32'(~vm + 33'd1);
		else if (raw33 > 33'h0_7FFF_FFFF)
			vel = 32'h7FFF_FFFF;
		else
			vel = raw33[31:0];
	end

	// unit start strobes
	always_comb begin
		cord_start = 1'b0;
		div_start = 1'b0;
		div_dividend = tmag_q;
		if (state_q == S_MUL && ph_q && step_q == ST_RADM)
			cord_start = 1'b1;
		if (state_q == S_MUL && ph_q && step_q == ST_YH)
			div_start = 1'b1;
		if (state_q == S_RMUL && ph_q && step_q == ST_RM) begin
			div_start = 1'b1;
			div_dividend = prod_q;
		end
		if (state_q == S_DIV2 && div_done && !pass_q) begin
			div_start = 1'b1;
			div_dividend = radm_q;
		end
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= ST_TL;
			ph_q <= 1'b0;
			pass_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_q <= '0;
			mpt_q <= MPT_RESET;
			tpm_q <= TPM_RESET;
			last_left_q <= '0;
			last_right_q <= '0;
			x_q <= '0;
			y_q <= '0;
			ang_q <= '0;
			smag_q <= '0;
			sneg_q <= 1'b0;
			dmag_q <= '0;
			dneg_q <= 1'b0;
			us_q <= '0;
			move_q <= 1'b0;
			tmag_q <= '0;
			m_q <= '0;
			lo_q <= '0;
			ht_q <= '0;
			p5_q <= '0;
			radm_q <= '0;
			plo_q <= '0;
			a_q <= '0;
			abig_q <= 1'b0;
			r_q <= '0;
			am_q <= '0;
			lin_q <= '0;
			angv_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MPT: mpt_q <= cfg_data;
					REG_TPM: tpm_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_left_q <= s_tdata[31:0];
						last_right_q <= s_tdata[63:32];
						sneg_q <= sum33[32];
						smag_q <= sum33[32] ? (~sum33 + 33'd1) : sum33;
						dneg_q <= dd33[32];
						dmag_q <= dmag33[31:0];
						us_q <= s_tdata[87:64];
						move_q <= (sum33 != 33'd0) && (mpt_q != 32'd0);
						step_q <= ST_TL;
						ph_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL, S_RMUL: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						step_q <= step_q + 4'd1;
						case (step_q)
							ST_TL: tmag_q <= 64'(({1'b0, prod_q} +
								(smag_q[32] ? {1'b0, mpt_q, 32'd0} : 65'd0) +
								{64'd0, sneg_q}) >> 1);
							ST_M: m_q <= prod_q;
							ST_LO: lo_q <= prod_q;
							ST_HT: ht_q <= prod_q;
							ST_P5: p5_q <= prod_q;
							ST_RADM: begin
								radm_q <= {prod_q[60:0], 3'b000} + {29'd0, p5_q[63:29]};
								state_q <= S_CORD;
							end
							ST_CL, ST_SL: plo_q <= prod_q;
							ST_XH: begin
								if (move_q)
									x_q <= sat32($signed(xs));
							end
							ST_YH: begin
								if (move_q)
									y_q <= sat32($signed(ys));
								pass_q <= 1'b0;
								state_q <= S_DIV1;
							end
							ST_AM: am_q <= prod_q[47:0];
							ST_RM: state_q <= S_DIV2;
							default: ;
						endcase
					end
				end
				S_CORD: begin
					if (cord_done)
						state_q <= S_MUL;
				end
				S_DIV1: begin
					if (div_done) begin
						a_q <= div_quot[27:0];
						abig_q <= |div_quot[63:28];
						r_q <= div_rem;
						step_q <= ST_AM;
						ph_q <= 1'b0;
						state_q <= S_RMUL;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						if (!pass_q) begin
							lin_q <= vel;
							pass_q <= 1'b1;
							state_q <= S_DIV1;
						end else begin
							angv_q <= vel;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_q <= {angv_q, lin_q, ang_q + dth, y_q, x_q};
						ang_q <= ang_q + dth;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTH
	a_cord_done_in_cord: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> (state_q == S_CORD))
		else $error("cordic done outside cordic wait");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider done outside divide wait");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after a transaction");

	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DONE) |=> $stable(ang_q))
		else $error("heading changed outside result load");
`endif
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ddo_pkg::*;

	// one encoder sample as the block sees it
	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		logic [23:0] us;
	} sample_t;

	// one pose/velocity result
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hdg;
		logic [31:0] lin;
		logic [31:0] ang;
	} pose_t;

	// index past the register list, must be ignored by the block
	localparam logic [IDX_W-1:0] REG_NONE = 8'd2;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint MASK32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] TURN_CAP = 64'h0010_0000_0000_0000;

	// atan(2^-k) in binary angle units
	localparam int unsigned ATAN_TAB [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;	// left_count, right_count, elapsed_us
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;	// pos_x, pos_y, heading, lin_vel, ang_vel
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	diff_drive_odometry_unit dut (.*);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Odometry predictor: own copy of scale registers and pose state
	// ---------------------------------------------------------------
	logic [31:0] scale_mpt, scale_tpm;
	logic [31:0] prev_left, prev_right;
	longint odo_x, odo_y;
	logic [31:0] odo_hdg;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// rotation-mode CORDIC, angle folded into +-quarter turn first
	task automatic cos_sin(input logic [31:0] ang, output longint c, output longint s);
		logic [31:0] a;
		logic flip;
		longint cx, cy, z, sx, sy;
		a = ang;
		flip = a + 32'h4000_0000 >= 32'h8000_0000;
		if (flip) a = a + 32'h8000_0000;
		z = longint'($signed(a));
		cx = longint'(CORDIC_GAIN);
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			sx = cy >>> (i % 32);
			sy = cx >>> (i % 32);
			if (z >= 0) begin
				cx = cx - sx; cy = cy + sy; z = z - longint'(ATAN_TAB[i % 32]);
			end else begin
				cx = cx + sx; cy = cy - sy; z = z + longint'(ATAN_TAB[i % 32]);
			end
		end
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;
	endtask

	// Q.16 times Q2.30, truncated toward zero
	function automatic longint scale_q30(input longint a, input longint c);
		logic neg;
		logic [63:0] ua, uc, r;
		neg = (a < 0) != (c < 0);
		ua = (a < 0) ? -a : a;
		uc = (c < 0) ? -c : c;
		r = (((ua >> 32) * uc) << 2) + (((ua & MASK32) * uc) >> 30);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// magnitude in Q.32 per elapsed microseconds -> Q16.16 per second, saturated
	function automatic logic [31:0] per_second(input logic neg, input logic [63:0] mag,
			input logic [23:0] us);
		logic [63:0] q, rem, raw, u;
		if (us == 0) return 32'd0;
		u = 64'(us);
		q = mag / u;
		rem = mag % u;
		if (q >= 64'd1 << 28)
			raw = 64'd1 << 32;
		else
			raw = (q * 64'(US_PER_S) + (rem * 64'(US_PER_S)) / u) >> 16;
		if (neg) begin
			if (raw > 64'h8000_0000) raw = 64'h8000_0000;
			return 32'(-raw);
		end
		if (raw > 64'h7FFF_FFFF) raw = 64'h7FFF_FFFF;
		return raw[31:0];
	endfunction

	task automatic odometry_step(input sample_t smp, output pose_t res);
		logic [31:0] dlu, dru, dth;
		longint dl, dr, mpt, lt, rt, travel, dd, c, s, tr16;
		logic [63:0] prod, m, ht, tm, radm;
		dlu = smp.left - prev_left;
		dru = smp.right - prev_right;
		dl = longint'($signed(dlu));
		dr = longint'($signed(dru));
		prev_left = smp.left;
		prev_right = smp.right;
		mpt = longint'({32'd0, scale_mpt});
		lt = dl * mpt;
		rt = dr * mpt;
		travel = (lt >>> 1) + (rt >>> 1) + (lt & rt & 64'sd1);
		dd = dr - dl;
		prod = 64'(dd) * 64'(scale_mpt) * 64'(scale_tpm);
		dth = prod[55:24];
		// position moves only with net travel; heading turns regardless
		if (dl + dr != 0 && scale_mpt != 0) begin
			tr16 = travel >>> 16;
			cos_sin(odo_hdg - dth, c, s);
			odo_x = clamp32(odo_x + scale_q30(tr16, c));
			odo_y = clamp32(odo_y + scale_q30(tr16, s));
		end
		odo_hdg = odo_hdg + dth;
		res.lin = per_second(travel < 0, (travel < 0) ? 64'(-travel) : 64'(travel), smp.us);
		// turns capped at 2^20 before going to radians
		m = ((dd < 0) ? 64'(-dd) : 64'(dd)) * 64'(scale_mpt);
		ht = (m >> 32) * 64'(scale_tpm);
		if (ht >= 64'd1 << 44)
			tm = TURN_CAP;
		else begin
			tm = (ht << 8) + (((m & MASK32) * 64'(scale_tpm)) >> 24);
			if (tm > TURN_CAP) tm = TURN_CAP;
		end
		radm = (((tm >> 32) * 64'(TWO_PI_Q29)) << 3) + (((tm & MASK32) * 64'(TWO_PI_Q29)) >> 29);
		res.ang = per_second(dd < 0, radm, smp.us);
		res.x = odo_x[31:0];
		res.y = odo_y[31:0];
		res.hdg = odo_hdg;
	endtask

	// ---------------------------------------------------------------
	// Driver: samples fed from a queue, bursts with random gaps
	// ---------------------------------------------------------------
	sample_t sample_q[$];
	pose_t pose_q[$];
	int n_queued = 0, n_taken = 0;
	logic s_taken = 1'b0;
	int burst_left = 0, gap_left = 0;
	logic failed = 1'b0;

	always @(negedge clk) begin
		sample_t cur;
		if (arst_n && !(s_tvalid && !s_taken)) begin
			if (gap_left > 0 || sample_q.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				cur = sample_q.pop_front();
				s_tdata <= {cur.us, cur.right, cur.left};
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
				end else
					burst_left--;
			end
		end
	end

	// receiver stall pattern: long ready stretches, random stalls, stall bursts
	int cyc = 0;
	always @(negedge clk) begin
		cyc++;
		case (cyc[10:9])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= $urandom_range(0, 3) != 0;
			2'd2: m_tready <= cyc[4:0] < 5'd20;
			default: m_tready <= $urandom_range(0, 1);
		endcase
	end

	// ---------------------------------------------------------------
	// Monitors: predict on input transaction, check on output transaction
	// ---------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		sample_t smp;
		pose_t exp_p, got;
		s_taken <= s_tvalid && s_tready;
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MPT) scale_mpt = cfg_data;
			else if (cfg_index == REG_TPM) scale_tpm = cfg_data;
		end
		if (arst_n && s_tvalid && s_tready) begin
			smp.left = s_tdata[31:0];
			smp.right = s_tdata[63:32];
			smp.us = s_tdata[87:64];
			odometry_step(smp, exp_p);
			pose_q = {pose_q, exp_p};
			n_taken++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[31:0];
			got.y = m_tdata[63:32];
			got.hdg = m_tdata[95:64];
			got.lin = m_tdata[127:96];
			got.ang = m_tdata[159:128];
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				failed = 1'b1;
			end else begin
				exp_p = pose_q.pop_front();
				if (got.x !== exp_p.x) begin
					$display("%0t: pos_x exp %h got %h", $time, exp_p.x, got.x);
					failed = 1'b1;
				end
				if (got.y !== exp_p.y) begin
					$display("%0t: pos_y exp %h got %h", $time, exp_p.y, got.y);
					failed = 1'b1;
				end
				if (got.hdg !== exp_p.hdg) begin
					$display("%0t: heading exp %h got %h", $time, exp_p.hdg, got.hdg);
					failed = 1'b1;
				end
				if (got.lin !== exp_p.lin) begin
					$display("%0t: lin_vel exp %h got %h", $time, exp_p.lin, got.lin);
					failed = 1'b1;
				end
				if (got.ang !== exp_p.ang) begin
					$display("%0t: ang_vel exp %h got %h", $time, exp_p.ang, got.ang);
					failed = 1'b1;
				end
			end
		end
		// watchdog: no transaction on any channel for too long
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic [31:0] gen_left = '0, gen_right = '0;

	task automatic push_abs(input logic [31:0] l, input logic [31:0] r, input logic [23:0] us);
		sample_t smp;
		smp.left = l;
		smp.right = r;
		smp.us = us;
		gen_left = l;
		gen_right = r;
		sample_q = {sample_q, smp};
		n_queued++;
	endtask

	function automatic logic [31:0] rand_delta();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1, 2, 3, 4, 5: return 32'($urandom_range(0, 4000)) - 32'd2000;
			6: return 32'($urandom_range(0, 400000)) - 32'd200000;
			7: return $urandom;
			8: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(0, 60)) - 32'd30;
		endcase
	endfunction

	function automatic logic [23:0] rand_us();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return $urandom_range(0, 1) ? 24'd1 : 24'hFF_FFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(1000, 100000));
		endcase
	endfunction

	// driving motion mixes: straight, near straight, spin in place, free
	task automatic push_random(input int n);
		logic [31:0] dl, dr;
		for (int i = 0; i < n; i++) begin
			dl = rand_delta();
			case ($urandom_range(0, 5))
				0: dr = dl;
				1: dr = -dl;
				2: dr = dl + 32'($urandom_range(0, 20)) - 32'd10;
				default: dr = rand_delta();
			endcase
			push_abs(gen_left + dl, gen_right + dr, rand_us());
		end
	endtask

	// hold the feed until every result is back, then let the block settle
	task automatic drain();
		while (n_taken != n_queued || pose_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		scale_mpt = MPT_RESET;
		scale_tpm = TPM_RESET;
		prev_left = '0;
		prev_right = '0;
		odo_x = 0;
		odo_y = 0;
		odo_hdg = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: no motion, zero time, straight, spin, counter wrap, extremes
		push_abs(32'd0, 32'd0, 24'd0);
		push_abs(32'd100, 32'd100, 24'd10000);
		push_abs(32'd100, 32'd100, 24'd0);
		push_abs(32'd200, 32'd0, 24'd5000);
		push_abs(32'd300, 32'd100, 24'd0);
		push_abs(32'd250, 32'd150, 24'd1);
		push_abs(32'h7FFF_FFF0, 32'h7FFF_FFF0, 24'hFF_FFFF);
		push_abs(32'h8000_0010, 32'h8000_0010, 24'd20000);
		push_abs(32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
		push_abs(32'h0000_0000, 32'hFFFF_FFFF, 24'd1);
		push_abs(32'hFFFF_FFFF, 32'h0000_0000, 24'd1);
		push_abs(32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
		push_abs(32'h0, 32'h0, 24'd1);
		push_abs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1);
		push_abs(32'hFFFF_FFFE, 32'hFFFF_FFFE, 24'd1);
		push_abs(32'hFFFF_FFFE, 32'hFFFF_FFFE, 24'hAA_AAAA);
		push_abs(32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555);
		push_abs(32'h0, 32'h0, 24'hFF_FFFF);
		drain();

		push_random(700);
		drain();

		write_reg(REG_MPT, 32'hFFFF_FFFF);
		write_reg(REG_TPM, 32'd1);
		push_random(150);
		drain();

		write_reg(REG_MPT, 32'd1);
		write_reg(REG_TPM, 32'hFFFF_FFFF);
		push_random(150);
		drain();

		// zero scale: heading/velocity paths with no position update
		write_reg(REG_MPT, 32'd0);
		write_reg(REG_TPM, TPM_RESET);
		push_random(100);
		drain();

		write_reg(REG_NONE, 32'hDEAD_BEEF);
		write_reg(REG_MPT, 32'($urandom_range(1000000, 20000000)));
		write_reg(REG_TPM, 32'($urandom_range(1000000, 50000000)));
		push_random(300);
		drain();

		write_reg(REG_MPT, MPT_RESET);
		write_reg(REG_TPM, TPM_RESET);
		push_random(300);
		drain();

		if (!failed)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_div.sv
hw/rtl/ddo_cordic.sv
hw/rtl/diff_drive_odometry_unit.sv
tb/tb.sv
